/* src/assert_macros.svh */
// Assertion helpers for the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Plain property, checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Overlapping implication: cons must hold in the cycle where ante holds.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/whp_pkg.sv */
`timescale 1ns / 1ps

package whp_pkg;

  localparam int unsigned HdrLen  = 44;
  localparam int unsigned PosW    = 6;
  localparam logic [PosW-1:0] PosLast = PosW'(HdrLen - 1);

  localparam logic [PosW-1:0] PosChannels = 6'd22;
  localparam logic [PosW-1:0] PosRateLo   = 6'd24;
  localparam logic [PosW-1:0] PosRateHi   = 6'd27;
  localparam logic [PosW-1:0] PosBits     = 6'd34;
  localparam logic [PosW-1:0] PosLenLo    = 6'd40;

  localparam logic [7:0] Bits8  = 8'h08;
  localparam logic [7:0] Bits16 = 8'h10;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_DROP   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_DATA   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FMT_U8    = 2'd0,
    FMT_S16LE = 2'd1,
    FMT_OTHER = 2'd2
  } fmt_e;

  // Fixed header bytes: tags, fmt length and PCM code.
  function automatic logic hdr_check(input logic [PosW-1:0] pos);
    logic chk;
    case (pos) inside
      [6'd0:6'd3], [6'd8:6'd21], [6'd36:6'd39]: chk = 1'b1;
      default:                                  chk = 1'b0;
    endcase
    return chk;
  endfunction

  function automatic logic [7:0] hdr_expect(input logic [PosW-1:0] pos);
    logic [7:0] b;
    case (pos)
      6'd0:    b = "R";
      6'd1:    b = "I";
      6'd2:    b = "F";
      6'd3:    b = "F";
      6'd8:    b = "W";
      6'd9:    b = "A";
      6'd10:   b = "V";
      6'd11:   b = "E";
      6'd12:   b = "f";
      6'd13:   b = "m";
      6'd14:   b = "t";
      6'd15:   b = " ";
      6'd16:   b = 8'h10;
      6'd20:   b = 8'h01;
      6'd36:   b = "d";
      6'd37:   b = "a";
      6'd38:   b = "t";
      6'd39:   b = "a";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/wav_header_parser_top.sv */
`timescale 1ns / 1ps
//  channel  | dir | handshake                 | tdata / tuser
//  ---------+-----+---------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid_i/tready_o  | tdata: in_byte ; tuser: file_start
//  m_axis   | out | m_axis_tvalid_o/tready_i  | tdata: result fields ; tuser: kind
//
//  One byte per cycle sustained unless m_axis stalls. An accepted byte is held in
//  the input register and decoded into the result register when the decode step
//  advances. Parse state advances in the decode step itself, so bytes follow each
//  other with no gap. rst_ni clears the valid flags, the phase (header) and the byte
//  position. When m_axis stalls, the result register holds and the input register
//  still takes one more byte before s_axis_tready_o drops.
`include "assert_macros.svh"

module wav_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] file_start

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] channels, [39:8] sample_rate, [41:40] sample_format,
  // [73:42] data_length, [79:74] error_offset, [87:80] data_out
  output logic [87:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parse state
  whp_pkg::phase_e            phase_q, phase_d;
  logic [whp_pkg::PosW-1:0]   pos_q, pos_d;
  logic [7:0]                 chan_q, chan_d;
  logic [31:0]                rate_q, rate_d;
  whp_pkg::fmt_e              fmt_q, fmt_d;
  logic [31:0]                len_q, len_d;

  // Result register
  logic                       out_valid_q;
  whp_pkg::kind_e             out_kind_q;
  logic [87:0]                out_data_q;

  // Decode step
  logic                       advance;
  logic                       fire;
  whp_pkg::phase_e            phase_cur;
  logic [whp_pkg::PosW-1:0]   pos_cur;
  logic                       res_valid;
  whp_pkg::kind_e             res_kind;
  logic [87:0]                res_data;

  // The decode stage moves whenever the result register is free or draining.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  always_comb begin
    // A start flag restarts the parse at header byte 0.
    phase_cur = in_start_q ? whp_pkg::PH_HEADER : phase_q;
    pos_cur   = in_start_q ? '0 : pos_q;

    phase_d   = phase_q;
    pos_d     = pos_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    fmt_d     = fmt_q;
    len_d     = len_q;
    res_valid = 1'b0;
    res_kind  = whp_pkg::KIND_DATA;
    res_data  = '0;

    if (fire) begin
      phase_d = phase_cur;
      pos_d   = pos_cur;
      case (phase_cur)
        whp_pkg::PH_DATA: begin
          res_valid       = 1'b1;
          res_kind        = whp_pkg::KIND_DATA;
          res_data[87:80] = in_byte_q;
        end
        whp_pkg::PH_HEADER: begin
          if (pos_cur > whp_pkg::PosLast) begin
            phase_d = whp_pkg::PH_DROP;
          end else if (whp_pkg::hdr_check(pos_cur) &&
                       (in_byte_q != whp_pkg::hdr_expect(pos_cur))) begin
            phase_d         = whp_pkg::PH_DROP;
            res_valid       = 1'b1;
            res_kind        = whp_pkg::KIND_ERROR;
            res_data[79:74] = pos_cur;
          end else begin
            // Little-endian fields: low two position bits pick the byte lane.
            if (pos_cur == whp_pkg::PosChannels) begin
              chan_d = in_byte_q;
            end else if ((pos_cur >= whp_pkg::PosRateLo) &&
                         (pos_cur <= whp_pkg::PosRateHi)) begin
              rate_d[{pos_cur[1:0], 3'b000} +: 8] = in_byte_q;
            end else if (pos_cur == whp_pkg::PosBits) begin
              if (in_byte_q == whp_pkg::Bits8) begin
                fmt_d = whp_pkg::FMT_U8;
              end else if (in_byte_q == whp_pkg::Bits16) begin
                fmt_d = whp_pkg::FMT_S16LE;
              end else begin
                fmt_d = whp_pkg::FMT_OTHER;
              end
            end else if (pos_cur >= whp_pkg::PosLenLo) begin
              len_d[{pos_cur[1:0], 3'b000} +: 8] = in_byte_q;
            end

            if (pos_cur == whp_pkg::PosLast) begin
              // Header complete; position stays parked at the last byte.
              phase_d         = whp_pkg::PH_DATA;
              res_valid       = 1'b1;
              res_kind        = whp_pkg::KIND_HEADER;
              res_data[7:0]   = chan_d;
              res_data[39:8]  = rate_d;
              res_data[41:40] = fmt_d;
              res_data[73:42] = len_d;
            end else begin
              pos_d = pos_cur + whp_pkg::PosW'(1);
            end
          end
        end
        default: ;  // dropping: bytes vanish until the next start
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= whp_pkg::PH_HEADER;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // Every capture field is rewritten by the time the header result is built; the result reads the next-state values.
  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
    rate_q <= rate_d;
    fmt_q  <= fmt_d;
    len_q  <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = out_data_q;

  // Position never runs past the last header byte.
  `ASSERT_ALWAYS(a_pos_bound, clk_i, rst_ni, pos_q <= whp_pkg::PosLast)
  // Data phase is entered only from the last header byte.
  `ASSERT_IMPLIES(a_data_pos, clk_i, rst_ni, phase_q == whp_pkg::PH_DATA,
                  pos_q == whp_pkg::PosLast)
  // Error results carry only an in-header offset.
  `ASSERT_IMPLIES(a_err_fields, clk_i, rst_ni,
                  out_valid_q && (out_kind_q == whp_pkg::KIND_ERROR),
                  (out_data_q[79:74] <= whp_pkg::PosLast) &&
                  (out_data_q[73:0] == '0) && (out_data_q[87:80] == '0))
  // A header result is always followed by the data phase unless restarted.
  `ASSERT_NEXT(a_hdr_to_data, clk_i, rst_ni,
               fire && res_valid && (res_kind == whp_pkg::KIND_HEADER),
               phase_q == whp_pkg::PH_DATA)
  // An empty input register never back-pressures the source.
  `ASSERT_IMPLIES(a_ready_empty, clk_i, rst_ni, !in_valid_q, s_axis_tready_o)

endmodule

/* tb/tb_wav_header_parser_top.sv */
`timescale 1ns / 1ps

module tb_wav_header_parser_top;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] in_byte
  logic        s_axis_tuser_i = 1'b0;   // [0] file_start

  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] channels, [39:8] sample_rate, [41:40] sample_format,
  // [73:42] data_length, [79:74] error_offset, [87:80] data_out
  logic [87:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;          // [1:0] kind

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  wav_header_parser_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct {
    whp_pkg::kind_e kind;
    logic [7:0]     channels;
    logic [31:0]    rate;
    whp_pkg::fmt_e  fmt;
    logic [31:0]    dlen;
    logic [5:0]     err_pos;
    logic [7:0]     payload;
  } wav_result_t;

  // How a directed row is checked: typed-in outcome or parser prediction.
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_ERROR
  } row_check_e;

  typedef struct {
    logic [7:0] b;
    logic       st;
    row_check_e chk;
    logic [5:0] pos;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------------
  logic [5:0]      hdr_pos;
  whp_pkg::phase_e hdr_phase;
  logic [7:0]      cap_channels;
  logic [31:0]     cap_rate;
  whp_pkg::fmt_e   cap_fmt;
  logic [31:0]     cap_len;

  wav_result_t pending_results[$];

  int unsigned err_cnt = 0;
  int unsigned sent_bytes = 0;
  bit          lazy_en = 1'b1;
  int unsigned hold_req = 0;

  // Fields of the transaction on s_axis, held while tvalid is up.
  row_check_e  cur_chk = EXP_PREDICT;
  logic [5:0]  cur_pos = '0;

  // {checked, expected value} for one header position
  function automatic logic [8:0] header_rule(input logic [5:0] pos);
    logic       chk;
    logic [7:0] v;
    chk = (pos <= 6'd3) || (pos >= 6'd8 && pos <= 6'd21) || (pos >= 6'd36 && pos <= 6'd39);
    case (pos)
      6'd0:    v = "R";
      6'd1:    v = "I";
      6'd2:    v = "F";
      6'd3:    v = "F";
      6'd8:    v = "W";
      6'd9:    v = "A";
      6'd10:   v = "V";
      6'd11:   v = "E";
      6'd12:   v = "f";
      6'd13:   v = "m";
      6'd14:   v = "t";
      6'd15:   v = " ";
      6'd16:   v = 8'h10;
      6'd20:   v = 8'h01;
      6'd36:   v = "d";
      6'd37:   v = "a";
      6'd38:   v = "t";
      6'd39:   v = "a";
      default: v = 8'h00;
    endcase
    return {chk, v};
  endfunction

  task automatic clear_parser();
    hdr_pos      = '0;
    hdr_phase    = whp_pkg::PH_HEADER;
    cap_channels = '0;
    cap_rate     = '0;
    cap_fmt      = whp_pkg::FMT_U8;
    cap_len      = '0;
  endtask

  // One byte through the parser model; has is set when a result is due.
  task automatic parse_wav_byte(input logic [7:0] b, input logic st,
                                output bit has, output wav_result_t r);
    logic [8:0] rule;
    r.kind     = whp_pkg::KIND_HEADER;
    r.channels = '0;
    r.rate     = '0;
    r.fmt      = whp_pkg::FMT_U8;
    r.dlen     = '0;
    r.err_pos  = '0;
    r.payload  = '0;
    has        = 1'b0;
    if (st) clear_parser();
    case (hdr_phase)
      whp_pkg::PH_DATA: begin
        has       = 1'b1;
        r.kind    = whp_pkg::KIND_DATA;
        r.payload = b;
      end
      whp_pkg::PH_HEADER: begin
        rule = header_rule(hdr_pos);
        if (hdr_pos >= 6'(whp_pkg::HdrLen)) begin
          hdr_phase = whp_pkg::PH_DROP;
        end else if (rule[8] && b != rule[7:0]) begin
          hdr_phase = whp_pkg::PH_DROP;
          has       = 1'b1;
          r.kind    = whp_pkg::KIND_ERROR;
          r.err_pos = hdr_pos;
        end else begin
          if (hdr_pos == 6'd22) cap_channels = b;
          else if (hdr_pos >= 6'd24 && hdr_pos <= 6'd27)
            cap_rate[8*(int'(hdr_pos) - 24) +: 8] = b;
          else if (hdr_pos == 6'd34)
            cap_fmt = (b == whp_pkg::Bits8) ? whp_pkg::FMT_U8 :
                      (b == whp_pkg::Bits16) ? whp_pkg::FMT_S16LE : whp_pkg::FMT_OTHER;
          else if (hdr_pos >= 6'd40)
            cap_len[8*(int'(hdr_pos) - 40) +: 8] = b;
          if (hdr_pos == 6'(whp_pkg::HdrLen - 1)) begin
            hdr_phase  = whp_pkg::PH_DATA;
            has        = 1'b1;
            r.channels = cap_channels;
            r.rate     = cap_rate;
            r.fmt      = cap_fmt;
            r.dlen     = cap_len;
          end else begin
            hdr_pos = hdr_pos + 6'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", name, e, a, $realtime);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts on s_axis transactions, checks m_axis transactions
  // ---------------------------------------------------------------------------
  initial clear_parser();

  always @(posedge clk_i) begin
    bit          has;
    wav_result_t r;
    wav_result_t e;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      parse_wav_byte(s_axis_tdata_i, s_axis_tuser_i, has, r);
      case (cur_chk)
        EXP_PREDICT: if (has) pending_results.push_back(r);
        EXP_ERROR: begin
          r.kind     = whp_pkg::KIND_ERROR;
          r.channels = '0;
          r.rate     = '0;
          r.fmt      = whp_pkg::FMT_U8;
          r.dlen     = '0;
          r.err_pos  = cur_pos;
          r.payload  = '0;
          pending_results.push_back(r);
        end
        default: ;
      endcase
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result kind %0d data %h at %0t",
                   m_axis_tuser_o, m_axis_tdata_o, $realtime);
      end else begin
        e = pending_results.pop_front();
        check_field("kind",          32'(e.kind),  32'(m_axis_tuser_o));
        check_field("channels",      32'(e.channels), 32'(m_axis_tdata_o[7:0]));
        check_field("sample_rate",   e.rate,       m_axis_tdata_o[39:8]);
        check_field("sample_format", 32'(e.fmt),   32'(m_axis_tdata_o[41:40]));
        check_field("data_length",   e.dlen,       m_axis_tdata_o[73:42]);
        check_field("error_offset",  32'(e.err_pos), 32'(m_axis_tdata_o[79:74]));
        check_field("data_out",      32'(e.payload), 32'(m_axis_tdata_o[87:80]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready_i <= 1'b0;
      end else if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 300;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(lazy_en && $urandom_range(99) < 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Entered and left at a rising edge; returns once the byte is accepted.
  task automatic send_byte(input logic [7:0] b, input logic st,
                           input row_check_e chk, input logic [5:0] pos);
    while (lazy_en && $urandom_range(99) < 25) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= st;
    cur_chk         <= chk;
    cur_pos         <= pos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Canonical header; corrupt_at >= 0 flips the byte at that position, n_bytes < 44 cuts it short.
  task automatic send_header(input logic [7:0] ch, input logic [31:0] rate,
                             input logic [7:0] bits, input logic [31:0] dlen,
                             input int corrupt_at, input int n_bytes);
    logic [7:0] hdr [44];
    logic [8:0] rule;
    for (int i = 0; i < 44; i++) hdr[i] = 8'($urandom);
    for (int i = 0; i < 44; i++) begin
      rule = header_rule(6'(i));
      if (rule[8]) hdr[i] = rule[7:0];
    end
    hdr[22] = ch;
    for (int i = 0; i < 4; i++) begin
      hdr[24 + i] = rate[8*i +: 8];
      hdr[40 + i] = dlen[8*i +: 8];
    end
    hdr[34] = bits;
    if (corrupt_at >= 0) hdr[corrupt_at] = hdr[corrupt_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n_bytes; i++) send_byte(hdr[i], i == 0, EXP_PREDICT, '0);
  endtask

  // Short directed run; every row here has a plain typed-in outcome.
  dir_row_t dir_rows [21] = '{
    '{"R",   1'b0, EXP_NONE,  6'd0},   // no start after reset: still header byte 0
    '{"X",   1'b0, EXP_ERROR, 6'd1},
    '{8'hFF, 1'b0, EXP_NONE,  6'd0},   // dropping
    '{8'h00, 1'b0, EXP_NONE,  6'd0},
    '{"R",   1'b1, EXP_NONE,  6'd0},   // start while dropping
    '{"I",   1'b0, EXP_NONE,  6'd0},
    '{"F",   1'b0, EXP_NONE,  6'd0},
    '{"F",   1'b0, EXP_NONE,  6'd0},
    '{8'h00, 1'b0, EXP_NONE,  6'd0},   // bytes 4-7 are not checked
    '{8'hFF, 1'b0, EXP_NONE,  6'd0},
    '{8'h80, 1'b0, EXP_NONE,  6'd0},
    '{8'h7F, 1'b0, EXP_NONE,  6'd0},
    '{"W",   1'b0, EXP_NONE,  6'd0},
    '{"A",   1'b0, EXP_NONE,  6'd0},
    '{"V",   1'b0, EXP_NONE,  6'd0},
    '{"D",   1'b0, EXP_ERROR, 6'd11},
    '{8'h00, 1'b1, EXP_ERROR, 6'd0},
    '{"R",   1'b1, EXP_NONE,  6'd0},
    '{8'hFF, 1'b0, EXP_ERROR, 6'd1},
    '{"R",   1'b1, EXP_NONE,  6'd0},
    '{"I",   1'b1, EXP_ERROR, 6'd0}    // start in mid-header
  };

  initial begin
    int         pick;
    int         idx;
    logic [7:0] bits_sel [4];
    bits_sel = '{8'h08, 8'h10, 8'h00, 8'hFF};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].st, dir_rows[i].chk,
                                    dir_rows[i].pos);

    for (int g = 0; sent_bytes < 1300; g++) begin
      lazy_en = !(g >= 30 && g < 45);
      pick    = $urandom_range(99);
      if (g < 4) begin
        // extreme header fields and payload bytes
        send_header(g[0] ? 8'hFF : 8'h00, g[0] ? 32'hFFFF_FFFF : 32'h0, bits_sel[g],
                    g[1] ? 32'hFFFF_FFFF : 32'h0, -1, 44);
        send_byte(8'h00, 1'b0, EXP_PREDICT, '0);
        send_byte(8'hFF, 1'b0, EXP_PREDICT, '0);
        send_byte(8'h80, 1'b0, EXP_PREDICT, '0);
      end else if (g == 12) begin
        // long receiver hold-off while the payload keeps coming
        send_header(8'($urandom), $urandom, 8'h10, $urandom, -1, 44);
        hold_req++;
        repeat (60) send_byte(8'($urandom), 1'b0, EXP_PREDICT, '0);
      end else if (pick < 60) begin
        send_header(8'($urandom), $urandom, bits_sel[$urandom_range(3)] ^
                    (($urandom_range(3) == 0) ? 8'($urandom) : 8'h00), $urandom, -1, 44);
        repeat ($urandom_range(16)) send_byte(8'($urandom), 1'b0, EXP_PREDICT, '0);
      end else if (pick < 78) begin
        idx = $urandom_range(21);
        idx = (idx < 4) ? idx : (idx < 18) ? idx + 4 : idx + 18;
        send_header(8'($urandom), $urandom, 8'h08, $urandom, idx, 44);
      end else if (pick < 88) begin
        send_header(8'($urandom), $urandom, 8'h10, $urandom, -1, $urandom_range(1, 43));
      end else begin
        repeat ($urandom_range(1, 12))
          send_byte(8'($urandom), $urandom_range(7) == 0, EXP_PREDICT, '0);
      end
      if (g == 20 || g == 60) wait_drained();
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    for (int i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (err_cnt == 0) begin
      $display("PASS wav_header_parser_top");
    end else begin
      $display("FAIL wav_header_parser_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL wav_header_parser_top");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/whp_pkg.sv
src/wav_header_parser_top.sv
tb/tb_wav_header_parser_top.sv
